@@ design/sntp_reply_median_offset_top_macros.svh @@
// Assertion macros shared by the SNTP median offset filter modules.
// Included by the queue and back-end modules; no other dependencies.
`ifndef SNTP_REPLY_MEDIAN_OFFSET_TOP_MACROS_SVH
`define SNTP_REPLY_MEDIAN_OFFSET_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMOF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMOF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/smof_pkg.sv @@
// Package for the SNTP median offset filter: status codes, constants, queue entry types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package smof_pkg;

  localparam int OFS_W = 34;

  // NTP era to Unix epoch distance in seconds
  localparam logic [OFS_W-1:0] NTP_UNIX_DELTA = 34'h0_83AA_7E80;
  localparam logic [7:0]       MAX_STRATUM_RST = 8'd14;
  localparam logic [1:0]       LEAP_ALARM = 2'b11;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ALARM   = 2'd1,
    ST_STRATUM = 2'd2
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic signed [OFS_W-1:0] sample;
  } cls_item_t;

  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } q_entry_t;

endpackage
`default_nettype wire

@@ design/smof_in_if.sv @@
// Request channel of the SNTP median offset filter: valid/ready plus one reply.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface smof_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] info_word;
  logic [31:0] recv_seconds;
  logic [31:0] local_seconds;

  modport source (output valid, output info_word, output recv_seconds,
                  output local_seconds, input ready);
  modport sink   (input valid, input info_word, input recv_seconds,
                  input local_seconds, output ready);
endinterface
`default_nettype wire

@@ design/smof_out_if.sv @@
// Result channel of the SNTP median offset filter: valid/ready plus one result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface smof_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [33:0] sample_offset;
  logic signed [33:0] system_offset;
  logic [3:0]        samples_held;

  modport source (output valid, output status, output sample_offset,
                  output system_offset, output samples_held, input ready);
  modport sink   (input valid, input status, input sample_offset,
                  input system_offset, input samples_held, output ready);
endinterface
`default_nettype wire

@@ design/smof_front.sv @@
// Front end: accepts requests, holds the stratum limit, classifies each reply.
// Depends on smof_pkg and smof_in_if.
`timescale 1ns / 1ps
`default_nettype none
module smof_front
  import smof_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  smof_in_if.sink       request,
  input  wire logic     cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic     q_ready,
  output q_entry_t      push
);

  logic [7:0] max_stratum;
  logic [1:0] leap;
  logic [7:0] stratum;
  status_t    status;

  // Hold the stratum limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_stratum <= MAX_STRATUM_RST;
    end else if (cfg_we) begin
      max_stratum <= cfg_wdata;
    end
  end

  // Classify the reply; alarm wins over stratum
  always_comb begin
    leap    = request.info_word[31:30];
    stratum = request.info_word[23:16];
    if (leap == LEAP_ALARM) begin
      status = ST_ALARM;
    end else if (stratum == 8'd0 || stratum > max_stratum) begin
      status = ST_STRATUM;
    end else begin
      status = ST_OK;
    end
  end

  // Form the sample offset and push toward the back end
  always_comb begin
    push.valid       = request.valid;
    push.item.status = status;
    if (status == ST_OK) begin
      push.item.sample = {2'b00, request.recv_seconds} - {2'b00, request.local_seconds}
                         - NTP_UNIX_DELTA;
    end else begin
      push.item.sample = '0;
    end
  end

  assign request.ready = q_ready;

endmodule
`default_nettype wire

@@ design/smof_queue.sv @@
// Two-entry queue between the classifying front end and the median back end.
// Depends on smof_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sntp_reply_median_offset_top_macros.svh"
module smof_queue
  import smof_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  q_entry_t  push,
  output logic      push_ready,
  output q_entry_t  head,
  input  wire logic pop
);

  cls_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (fill != 2'd0);
  assign head.valid = (fill != 2'd0);
  assign head.item  = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

  `SMOF_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= 2'd2, "queue overfilled")
  `SMOF_ASSERT_NOW(a_ptr_track, clk, rst, fill == 2'd0 || fill == 2'd2, wr_ptr == rd_ptr, "pointers out of step with fill")
  `SMOF_ASSERT_NEXT(a_pop_drains, clk, rst, do_pop && !do_push, fill == $past(fill) - 2'd1, "pop did not drain")

endmodule
`default_nettype wire

@@ design/smof_back.sv @@
// Back end: keeps the offset window, ranks it one sample a cycle, drives results.
// Depends on smof_pkg, smof_out_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sntp_reply_median_offset_top_macros.svh"
module smof_back
  import smof_pkg::*;
#(
  parameter int HELD_SAMPLES = 8,
  parameter int CNT_W        = 4,
  parameter int IDX_W        = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  input  q_entry_t  head,
  output logic      pop,
  smof_out_if.source result
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_RANK  = 3'b010,
    B_FINAL = 3'b100
  } back_state_t;

  back_state_t             state;
  logic signed [OFS_W-1:0] win [HELD_SAMPLES];
  logic [CNT_W-1:0]        count;
  logic [IDX_W-1:0]        oldest;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        wr_slot;
  logic                    full;
  logic                    out_free;
  logic signed [OFS_W-1:0] median;
  logic signed [OFS_W-1:0] mid_hi;
  logic signed [OFS_W-1:0] mid_lo;
  logic signed [OFS_W-1:0] cur;
  logic [CNT_W-1:0]        rank;
  logic [CNT_W-1:0]        half;
  logic signed [OFS_W:0]   pair_sum;
  logic signed [OFS_W:0]   pair_half;
  logic signed [OFS_W-1:0] mid_next;
  logic                    take_ok;

  assign full     = (count == CNT_W'(HELD_SAMPLES));
  assign out_free = !result.valid || result.ready;
  assign pop      = (state == B_IDLE) && head.valid && out_free;
  assign take_ok  = pop && (head.item.status == ST_OK);
  assign wr_slot  = full ? oldest : count[IDX_W-1:0];
  assign half     = count >> 1;

  // Rank the current sample against every held sample; ties break by slot
  always_comb begin
    cur  = win[idx];
    rank = '0;
    for (int j = 0; j < HELD_SAMPLES; j++) begin
      if (CNT_W'(j) < count &&
          (win[j] < cur || (win[j] == cur && IDX_W'(j) < idx))) begin
        rank = rank + CNT_W'(1);
      end
    end
  end

  // Average the middle pair toward zero, pick the middle, drop a one-second jitter
  always_comb begin
    pair_sum  = {mid_hi[OFS_W-1], mid_hi} + {mid_lo[OFS_W-1], mid_lo};
    pair_half = pair_sum >>> 1;
    if (count[0]) begin
      mid_next = mid_hi;
    end else begin
      mid_next = pair_half[OFS_W-1:0] + OFS_W'(pair_sum[OFS_W] & pair_sum[0]);
    end
    if (mid_next == OFS_W'(1) || mid_next == '1) begin
      mid_next = '0;
    end
  end

  // Write accepted samples into the ring
  always_ff @(posedge clk) begin
    if (take_ok) begin
      win[wr_slot] <= head.item.sample;
    end
  end

  // Capture the middle values during the scan
  always_ff @(posedge clk) begin
    if (state == B_RANK && CNT_W'(idx) < count) begin
      if (rank == half) begin
        mid_hi <= cur;
      end
      if (rank == half - CNT_W'(1)) begin
        mid_lo <= cur;
      end
    end
  end

  // Sequence the window update, the scan and the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      count        <= '0;
      oldest       <= '0;
      idx          <= '0;
      median       <= '0;
      result.valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (take_ok) begin
            if (full) begin
              oldest <= (oldest == IDX_W'(HELD_SAMPLES - 1)) ? '0 : oldest + IDX_W'(1);
            end else begin
              count <= count + CNT_W'(1);
            end
            idx   <= '0;
            state <= B_RANK;
          end
          // Raise a rejected result at once, or retire the one taken
          if (pop && head.item.status != ST_OK) begin
            result.valid <= 1'b1;
          end else if (result.valid && result.ready) begin
            result.valid <= 1'b0;
          end
        end
        B_RANK: begin
          if (idx == IDX_W'(HELD_SAMPLES - 1)) begin
            state <= B_FINAL;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        B_FINAL: begin
          median       <= mid_next;
          result.valid <= 1'b1;
          state        <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop && head.item.status != ST_OK) begin
      result.status        <= head.item.status;
      result.sample_offset <= '0;
      result.system_offset <= median;
      result.samples_held  <= 4'(count);
    end else if (take_ok) begin
      result.status        <= ST_OK;
      result.sample_offset <= head.item.sample;
    end else if (state == B_FINAL) begin
      result.system_offset <= mid_next;
      result.samples_held  <= 4'(count);
    end
  end

  `SMOF_ASSERT_NOW(a_final_free, clk, rst, state == B_FINAL, !result.valid,
                   "result slot busy at end of scan")
  `SMOF_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(HELD_SAMPLES),
                   "window count past depth")
  `SMOF_ASSERT_NEXT(a_count_grows, clk, rst, 1'b1, count >= $past(count),
                    "window count shrank")
  `SMOF_ASSERT_NOW(a_reject_zero, clk, rst, result.valid && result.status != ST_OK,
                   result.sample_offset == '0, "rejected reply carries an offset")

endmodule
`default_nettype wire

@@ design/sntp_reply_median_offset_top.sv @@
// SNTP reply median offset filter, top level.
// Request channel: valid/ready with info_word, recv_seconds and local_seconds of
// one reply. Result channel: valid/ready with status, sample_offset,
// system_offset and samples_held; exactly one result per accepted request.
// cfg_we/cfg_wdata write max_stratum (reset 14); the user must write it only while
// the block is idle, as the block does not enforce this. A two-entry queue parts
// request intake from the back end, so requests are taken while a result waits.
// A rejected reply's result is registered when the back end pops it from the queue.
// An accepted reply is written into the window, then the window is ranked one
// sample per cycle against all held samples; the back end takes no further queued
// reply while that rank scan runs.
// A stalled result holds its payload; the back end takes no queued reply until
// the result is taken, and the request side stalls once the queue is full.
// Synchronous reset empties the window and queue, zeroes the median and drops
// any pending result; the window needs no clearing pass.
// Depends on smof_pkg, smof_in_if, smof_out_if, smof_front, smof_queue, smof_back.
`timescale 1ns / 1ps
`default_nettype none
module sntp_reply_median_offset_top
  import smof_pkg::*;
#(
  parameter int HELD_SAMPLES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  smof_in_if.sink         request,
  smof_out_if.source      result,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  localparam int CNT_W = $clog2(HELD_SAMPLES + 1);
  localparam int IDX_W = (HELD_SAMPLES > 1) ? $clog2(HELD_SAMPLES) : 1;

  q_entry_t push;
  q_entry_t head;
  logic     q_ready;
  logic     pop;

  // Classify requests
  smof_front u_front (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_ready   (q_ready),
    .push      (push)
  );

  // Decouple front and back
  smof_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (q_ready),
    .head       (head),
    .pop        (pop)
  );

  // Update the window and rank it
  smof_back #(
    .HELD_SAMPLES (HELD_SAMPLES),
    .CNT_W        (CNT_W),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire
